>>> src/iac_pkg.sv
// Package for the intruder alarm controller: payload structs, mode and
// function codes, register indexes. No dependencies.
package iac_pkg;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMING   = 2'd1,
    MODE_ARMED    = 2'd2,
    MODE_ALARMING = 2'd3
  } mode_t;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ARM    = 2'd1;
  localparam logic [1:0] FUNC_DISARM = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [2:0] REG_EXIT_DELAY = 3'd0;
  localparam logic [2:0] REG_ALARM_DUR  = 3'd1;
  localparam logic [2:0] REG_RETRIGGER  = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd4;
  localparam logic [2:0] REG_BLINK_HALF = 3'd5;

  localparam int PIR_W = 4;

  typedef struct packed {
    logic [1:0]       func;
    logic             button_level;
    logic [PIR_W-1:0] pir_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0] alarm_state;
    logic       siren_on;
    logic       led_on;
    logic       state_changed;
  } out_item_t;

endpackage

>>> src/iac_queue.sv
// Short FIFO between the front and back parts of the alarm controller.
// Depends on nothing; width is a parameter.
module iac_queue #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             push, pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !out_valid) else $error("valid while empty");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("push lost");
endmodule

>>> src/iac_front.sv
// Front part: accepts items, keeps time, blink and button debounce state,
// and reduces each item to a mode request. Depends on iac_pkg.
module iac_front #(
  parameter int NUM_ZONES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iac_pkg::in_item_t    in_item,
  input  logic [31:0]          debounce_len,
  input  logic [31:0]          hold_len,
  input  logic [15:0]          blink_half_ms,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [1:0]           q_func,
  output logic                 q_toggle,
  output logic                 q_blink,
  output logic [NUM_ZONES-1:0] q_pirs
);
  logic [31:0] time_now, button_change_time, press_start;
  logic        button_prev, button_steady, press_active, long_done;
  logic [15:0] blink_count;
  logic        blink_phase;

  logic [31:0] now;
  logic [15:0] half, bc_inc;
  logic        accept, tick;
  logic        prev_n, steady_n, active_n, done_n, toggle;
  logic [31:0] change_n, pstart_n;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;
  assign tick     = (in_item.func == iac_pkg::FUNC_TICK);
  assign now      = time_now + 32'd1;
  assign half     = (blink_half_ms == 16'd0) ? 16'd1 : blink_half_ms;
  assign bc_inc   = blink_count + 16'd1;

  always_comb begin
    prev_n   = button_prev;
    change_n = button_change_time;
    steady_n = button_steady;
    pstart_n = press_start;
    active_n = press_active;
    done_n   = long_done;
    toggle   = 1'b0;
    if (in_item.button_level != button_prev) begin
      prev_n   = in_item.button_level;
      change_n = now;
    end
    if ((now - change_n) > debounce_len && in_item.button_level != button_steady) begin
      steady_n = in_item.button_level;
      active_n = !in_item.button_level;
      if (!in_item.button_level) begin
        pstart_n = now;
      end
      done_n = 1'b0;
    end
    if (!steady_n && !done_n && active_n && (now - pstart_n) >= hold_len) begin
      done_n = 1'b1;
      toggle = 1'b1;
    end
  end

  assign q_func   = in_item.func;
  assign q_toggle = tick && toggle;
  assign q_blink  = (tick && bc_inc >= half) ? !blink_phase : blink_phase;
  always_comb begin
    q_pirs = '0;
    for (int i = 0; i < NUM_ZONES; i++) begin
      if (i < iac_pkg::PIR_W) begin
        q_pirs[i] = in_item.pir_levels[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now           <= '0;
      button_prev        <= 1'b1;
      button_steady      <= 1'b1;
      button_change_time <= '0;
      press_start        <= '0;
      press_active       <= 1'b0;
      long_done          <= 1'b0;
      blink_count        <= '0;
      blink_phase        <= 1'b0;
    end else if (accept && tick) begin
      time_now           <= now;
      button_prev        <= prev_n;
      button_steady      <= steady_n;
      button_change_time <= change_n;
      press_start        <= pstart_n;
      press_active       <= active_n;
      long_done          <= done_n;
      blink_count        <= (bc_inc >= half) ? 16'd0 : bc_inc;
      blink_phase        <= q_blink;
    end
  end

  a_time_step: assert property (@(posedge clk) disable iff (rst)
    (accept && tick) |=> time_now == $past(time_now) + 32'd1) else $error("time skip");
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick) |=> $stable(time_now) && $stable(blink_count))
    else $error("command moved time");
  a_toggle_pressed: assert property (@(posedge clk) disable iff (rst)
    q_toggle |-> !steady_n) else $error("toggle while released");
endmodule

>>> src/iac_back.sv
// Back part: mode machine, exit delay, zone retrigger limit, alarm timer
// and result register. Depends on iac_pkg.
module iac_back #(
  parameter int NUM_ZONES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [1:0]           q_func,
  input  logic                 q_toggle,
  input  logic                 q_blink,
  input  logic [NUM_ZONES-1:0] q_pirs,
  input  logic [31:0]          exit_delay,
  input  logic [31:0]          alarm_len,
  input  logic [31:0]          retrigger_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iac_pkg::out_item_t   out_item
);
  iac_pkg::mode_t mode, mode_next, m1;
  logic [31:0] time_now, mode_since, alarm_end, now, since_next, end_next;
  logic [31:0] zone_last [NUM_ZONES];
  logic [NUM_ZONES-1:0] zone_hit;
  logic any_hit, entered, take, tick;
  logic [31:0] since1, end_diff;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign tick    = (q_func == iac_pkg::FUNC_TICK);
  assign now     = time_now + 32'd1;
  assign end_diff = now - alarm_end;

  always_comb begin
    for (int i = 0; i < NUM_ZONES; i++) begin
      zone_hit[i] = q_pirs[i] && ((now - zone_last[i]) >= retrigger_ms);
    end
  end
  assign any_hit = |zone_hit;

  always_comb begin
    m1     = mode;
    since1 = mode_since;
    if (q_toggle) begin
      m1     = (mode == iac_pkg::MODE_DISARMED) ? iac_pkg::MODE_ARMING
                                                 : iac_pkg::MODE_DISARMED;
      since1 = now;
    end
  end

  always_comb begin
    mode_next  = mode;
    since_next = mode_since;
    end_next   = alarm_end;
    entered    = 1'b0;
    unique case (q_func)
      iac_pkg::FUNC_TICK: begin
        mode_next  = m1;
        since_next = since1;
        entered    = q_toggle;
        unique case (m1)
          iac_pkg::MODE_ARMING: begin
            if ((now - since1) >= exit_delay) begin
              mode_next = iac_pkg::MODE_ARMED;
              since_next = now;
              entered = 1'b1;
            end
          end
          iac_pkg::MODE_ARMED: begin
            if (any_hit) begin
              mode_next = iac_pkg::MODE_ALARMING;
              since_next = now;
              end_next = now + alarm_len;
              entered = 1'b1;
            end
          end
          iac_pkg::MODE_ALARMING: begin
            if (!end_diff[31]) begin
              mode_next = iac_pkg::MODE_ARMED;
              since_next = now;
              entered = 1'b1;
            end
          end
          default: ;
        endcase
      end
      iac_pkg::FUNC_ARM: begin
        if (mode == iac_pkg::MODE_DISARMED) begin
          mode_next = iac_pkg::MODE_ARMING;
          since_next = time_now;
          entered = 1'b1;
        end
      end
      iac_pkg::FUNC_DISARM: begin
        mode_next = iac_pkg::MODE_DISARMED;
        since_next = time_now;
        entered = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.alarm_state   <= mode_next;
      out_item.siren_on      <= (mode_next == iac_pkg::MODE_ALARMING);
      out_item.led_on        <= mode_next[1] || !q_blink;
      out_item.state_changed <= entered;
    end
    if (rst) begin
      mode       <= iac_pkg::MODE_DISARMED;
      time_now   <= '0;
      mode_since <= '0;
      alarm_end  <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_ZONES; i++) zone_last[i] <= '0;
    end else begin
      if (take) begin
        out_valid  <= 1'b1;
        mode       <= mode_next;
        mode_since <= since_next;
        alarm_end  <= end_next;
        if (tick) begin
          time_now <= now;
          if (m1 == iac_pkg::MODE_ARMED) begin
            for (int i = 0; i < NUM_ZONES; i++) begin
              if (zone_hit[i]) zone_last[i] <= now;
            end
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_siren_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.siren_on == (out_item.alarm_state == iac_pkg::MODE_ALARMING)))
    else $error("siren mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_item)) else $error("result lost");
  a_disarm: assert property (@(posedge clk) disable iff (rst)
    (take && q_func == iac_pkg::FUNC_DISARM) |=> mode == iac_pkg::MODE_DISARMED)
    else $error("disarm ignored");
endmodule

>>> src/intruder_alarm_controller.sv
// Intruder alarm controller top level: config registers, front, queue, back.
// An input transfer passes through the queue and then the result register to the output.
// Throughput: one item per cycle while out_ready stays high; the two-entry queue
// and result register let both sides stall independently.
// Reset (synchronous, rst high): disarmed, time zero, registers to defaults.
// Depends on iac_pkg, iac_front, iac_queue, iac_back.
module intruder_alarm_controller #(
  parameter int NUM_ZONES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  iac_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output iac_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int QW = 2 + 1 + 1 + NUM_ZONES;

  logic [31:0] exit_delay, alarm_len, retrigger_ms, hold_len;
  logic [15:0] debounce_len, blink_half_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_delay    <= 32'd10000;
      alarm_len     <= 32'd30000;
      retrigger_ms  <= 32'd2000;
      hold_len      <= 32'd2000;
      debounce_len  <= 16'd40;
      blink_half_ms <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iac_pkg::REG_EXIT_DELAY: exit_delay    <= cfg_data;
        iac_pkg::REG_ALARM_DUR:  alarm_len     <= cfg_data;
        iac_pkg::REG_RETRIGGER:  retrigger_ms  <= cfg_data;
        iac_pkg::REG_LONG_PRESS: hold_len      <= cfg_data;
        iac_pkg::REG_DEBOUNCE:   debounce_len  <= cfg_data[15:0];
        iac_pkg::REG_BLINK_HALF: blink_half_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [1:0]           f_func, b_func;
  logic                 f_toggle, f_blink, b_toggle, b_blink;
  logic [NUM_ZONES-1:0] f_pirs, b_pirs;

  iac_front #(.NUM_ZONES(NUM_ZONES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .debounce_len({16'd0, debounce_len}), .hold_len, .blink_half_ms,
    .q_valid(f_valid), .q_ready(f_ready), .q_func(f_func),
    .q_toggle(f_toggle), .q_blink(f_blink), .q_pirs(f_pirs)
  );

  iac_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready),
    .in_data({f_func, f_toggle, f_blink, f_pirs}),
    .out_valid(b_valid), .out_ready(b_ready),
    .out_data({b_func, b_toggle, b_blink, b_pirs})
  );

  iac_back #(.NUM_ZONES(NUM_ZONES)) u_back (
    .clk, .rst, .q_valid(b_valid), .q_ready(b_ready), .q_func(b_func),
    .q_toggle(b_toggle), .q_blink(b_blink), .q_pirs(b_pirs),
    .exit_delay, .alarm_len, .retrigger_ms,
    .out_valid, .out_ready, .out_item
  );
endmodule
